[rtl/pdr_pkg.sv]
// ----------------------------------------------------------------------------
// Planar dead reckoning package
// Fixed-point constants, the sequencer state type and the CORDIC arctangent
// table shared by the dead reckoning block.
// ----------------------------------------------------------------------------
package pdr_pkg;

   // Default number of CORDIC rotations per sine/cosine evaluation.
   localparam int CORDIC_ITERATIONS_DEF = 24;

   // Angle and gain constants. Angles are Q3.29 radians, vectors are Q1.30.
   localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
   localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314856;
   localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

   // Opcode carried in the input item's tuser bit.
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INC,
      S_YAW,
      S_ROT,
      S_TRIG,
      S_MUL_XC,
      S_MUL_XT,
      S_MUL_YC,
      S_MUL_YT,
      S_ADD_Y,
      S_QUAT_INIT,
      S_OUT
   } state_type;

   // Arctangent of 2^-i in units of 2^-30 radians.
   function automatic logic [29:0] atan_lookup(input logic [4:0] idx);
      logic [29:0] val;
      unique case (idx)
         5'd0:  val = 30'd843314857;
         5'd1:  val = 30'd497837829;
         5'd2:  val = 30'd263043837;
         5'd3:  val = 30'd133525159;
         5'd4:  val = 30'd67021687;
         5'd5:  val = 30'd33543516;
         5'd6:  val = 30'd16775851;
         5'd7:  val = 30'd8388437;
         5'd8:  val = 30'd4194283;
         5'd9:  val = 30'd2097149;
         5'd10: val = 30'd1048576;
         5'd11: val = 30'd524288;
         5'd12: val = 30'd262144;
         5'd13: val = 30'd131072;
         5'd14: val = 30'd65536;
         5'd15: val = 30'd32768;
         5'd16: val = 30'd16384;
         5'd17: val = 30'd8192;
         5'd18: val = 30'd4096;
         5'd19: val = 30'd2048;
         5'd20: val = 30'd1024;
         5'd21: val = 30'd512;
         5'd22: val = 30'd256;
         5'd23: val = 30'd128;
         5'd24: val = 30'd64;
         5'd25: val = 30'd32;
         5'd26: val = 30'd16;
         5'd27: val = 30'd8;
         5'd28: val = 30'd4;
         5'd29: val = 30'd2;
         5'd30: val = 30'd1;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

   // Clamp a CORDIC vector component to [-1.0, 1.0] in Q1.30.
   function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > ONE_Q30) begin
         r = 32'sd1073741824;
      end else if (v < -ONE_Q30) begin
         r = -32'sd1073741824;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/planar_dead_reckoning.sv]
// ----------------------------------------------------------------------------
// Planar dead reckoning
// Unicycle odometry in fixed point: integrates yaw rate and forward speed
// into a Q32.16 position and a Q3.29 yaw, and reports the yaw quaternion.
// ----------------------------------------------------------------------------
// Usage:
// An input item on the req_ channel either loads a pose (tuser high) or
// integrates one motion update (tuser low). Every input item produces one
// result item on the rsp_ channel with the pose and cos/sin of half the yaw.
// The csr_ channel writes the enable bit; it is always ready, and it must
// only be written while no item is in flight. While enable is low, or the
// time step is zero, updates leave the pose unchanged.
// One input item is handled at a time; req_tready is low from acceptance
// until the result item has been taken. The work runs through a single
// shared CORDIC stage and a single shared multiplier under a sequencer.
// A load or a held update runs one CORDIC pass, for the quaternion; a
// motion update runs another pass before it, for the heading, and then
// the position multiplies. The CORDIC does one rotation per cycle.
// A stalled result simply waits in the output register until rsp_tready.
// Synchronous reset clears the pose and the enable bit and returns to idle.
// ----------------------------------------------------------------------------
module planar_dead_reckoning
   import pdr_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Input items.
   input  logic         req_tvalid,
   output logic         req_tready,
   // speed[31:0], yaw_rate[63:32], time_step[79:64],
   // load_x[127:80], load_y[175:128], load_yaw[207:176]
   input  logic [207:0] req_tdata,
   // opcode[0]
   input  logic         req_tuser,
   // Result items.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x[47:0], pos_y[95:48], heading[127:96], quat_w[159:128],
   // quat_z[191:160]
   output logic [191:0] rsp_tdata,
   // Enable register write.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERATIONS - 1);
   localparam logic signed [31:0] PI_YAW = PI_Q29[31:0];

   // Registers.
   state_type          state_ff, state_in;
   logic               enable_ff;
   logic signed [47:0] x_ff, x_in;
   logic signed [47:0] y_ff, y_in;
   logic signed [31:0] yaw_ff, yaw_in;
   logic [207:0]       data_ff;
   logic               op_ff;
   logic signed [65:0] prod_ff;
   logic signed [33:0] cx_ff, cx_in;
   logic signed [33:0] cy_ff, cy_in;
   logic signed [33:0] cz_ff, cz_in;
   logic [4:0]         iter_ff, iter_in;
   logic               neg_ff, neg_in;
   logic               quat_ff, quat_in;
   logic signed [31:0] cos_ff, cos_in;
   logic signed [31:0] sin_ff, sin_in;

   // Fields of the held input item.
   logic signed [31:0] vel;
   logic signed [31:0] omega;
   logic [15:0]        dt;
   logic signed [47:0] ld_x;
   logic signed [47:0] ld_y;
   logic signed [31:0] ld_yaw;

   assign vel    = data_ff[31:0];
   assign omega  = data_ff[63:32];
   assign dt     = data_ff[79:64];
   assign ld_x   = data_ff[127:80];
   assign ld_y   = data_ff[175:128];
   assign ld_yaw = data_ff[207:176];

   // Shared multiplier operands, chosen by the sequencer.
   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [65:0] mul_p;

   assign mul_p = {{32{mul_a[33]}}, mul_a} * {{34{mul_b[31]}}, mul_b};

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (op_ff == OP_LOAD) begin
               state_in = S_QUAT_INIT;
            end else if (enable_ff && (dt != 16'd0)) begin
               state_in = S_INC;
            end else begin
               state_in = S_QUAT_INIT;
            end
         end
         S_INC:       state_in = S_YAW;
         S_YAW:       state_in = S_ROT;
         S_ROT: begin
            if (iter_ff == ITER_LAST) begin
               state_in = S_TRIG;
            end
         end
         S_TRIG:      state_in = quat_ff ? S_OUT : S_MUL_XC;
         S_MUL_XC:    state_in = S_MUL_XT;
         S_MUL_XT:    state_in = S_MUL_YC;
         S_MUL_YC:    state_in = S_MUL_YT;
         S_MUL_YT:    state_in = S_ADD_Y;
         S_ADD_Y:     state_in = S_QUAT_INIT;
         S_QUAT_INIT: state_in = S_ROT;
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // Handshake and multiplier operand selection.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_OUT:  rsp_tvalid = 1'b1;
         S_INC: begin
            mul_a = {{2{omega[31]}}, omega};
            mul_b = {16'd0, dt};
         end
         S_MUL_XC: begin
            mul_a = {{2{vel[31]}}, vel};
            mul_b = cos_ff;
         end
         S_MUL_YC: begin
            mul_a = {{2{vel[31]}}, vel};
            mul_b = sin_ff;
         end
         S_MUL_XT, S_MUL_YT: begin
            mul_a = prod_ff[63:30];
            mul_b = {16'd0, dt};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Datapath helpers: yaw increment, wrap and quadrant fold.
   logic signed [65:0] inc_wide;
   logic signed [31:0] inc;
   logic signed [32:0] yaw_sum;
   logic signed [32:0] yaw_wrap;
   logic signed [31:0] yaw_new;
   logic signed [33:0] fold_a;
   logic signed [31:0] ld_yaw_sat;
   logic signed [33:0] xs, ys;
   logic signed [33:0] atan_val;
   logic signed [31:0] cl_x, cl_y;

   always_comb begin
      inc_wide = prod_ff >>> 3;
      if (inc_wide > 66'(PI_Q29)) begin
         inc = PI_Q29[31:0];
      end else if (inc_wide < -66'(PI_Q29)) begin
         inc = -PI_Q29[31:0];
      end else begin
         inc = inc_wide[31:0];
      end

      yaw_sum = {yaw_ff[31], yaw_ff} + {inc[31], inc};
      priority if (yaw_sum > 33'(PI_Q29)) begin
         yaw_wrap = yaw_sum - 33'(TWO_PI_Q29);
      end else if (yaw_sum < -33'(PI_Q29)) begin
         yaw_wrap = yaw_sum + 33'(TWO_PI_Q29);
      end else begin
         yaw_wrap = yaw_sum;
      end
      yaw_new = yaw_wrap[31:0];

      if (ld_yaw > PI_YAW) begin
         ld_yaw_sat = PI_YAW;
      end else if (ld_yaw < -PI_YAW) begin
         ld_yaw_sat = -PI_YAW;
      end else begin
         ld_yaw_sat = ld_yaw;
      end

      // Fold yaw into [-pi/2, pi/2] for the sine/cosine of the full yaw.
      fold_a = {{2{yaw_new[31]}}, yaw_new};
      if (fold_a > HALF_PI_Q29) begin
         fold_a = fold_a - PI_Q29;
      end else if (fold_a < -HALF_PI_Q29) begin
         fold_a = fold_a + PI_Q29;
      end

      xs       = cx_ff >>> iter_ff;
      ys       = cy_ff >>> iter_ff;
      atan_val = {4'd0, atan_lookup(iter_ff)};
      cl_x     = clamp_unit(cx_ff);
      cl_y     = clamp_unit(cy_ff);
   end

   // Datapath next values.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      yaw_in  = yaw_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      iter_in = iter_ff;
      neg_in  = neg_ff;
      quat_in = quat_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      unique case (state_ff)
         S_DECODE: begin
            if (op_ff == OP_LOAD) begin
               x_in   = ld_x;
               y_in   = ld_y;
               yaw_in = ld_yaw_sat;
            end
         end
         S_YAW: begin
            // New yaw, then start a CORDIC run on twice the folded angle.
            yaw_in  = yaw_new;
            cx_in   = GAIN_Q30;
            cy_in   = '0;
            cz_in   = fold_a <<< 1;
            neg_in  = (fold_a != {{2{yaw_new[31]}}, yaw_new});
            quat_in = 1'b0;
            iter_in = '0;
         end
         S_QUAT_INIT: begin
            // Quaternion run: the Q3.29 yaw read as 2^-30 units is yaw/2.
            cx_in   = GAIN_Q30;
            cy_in   = '0;
            cz_in   = {{2{yaw_ff[31]}}, yaw_ff};
            neg_in  = 1'b0;
            quat_in = 1'b1;
            iter_in = '0;
         end
         S_ROT: begin
            // One CORDIC rotation per cycle.
            if (!cz_ff[33]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_val;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_val;
            end
            iter_in = iter_ff + 5'd1;
         end
         S_TRIG: begin
            cos_in = neg_ff ? -cl_x : cl_x;
            sin_in = neg_ff ? -cl_y : cl_y;
         end
         S_MUL_YC: begin
            x_in = x_ff + prod_ff[63:16];
         end
         S_ADD_Y: begin
            y_in = y_ff + prod_ff[63:16];
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         enable_ff <= 1'b0;
         x_ff      <= '0;
         y_ff      <= '0;
         yaw_ff    <= '0;
         iter_ff   <= '0;
         neg_ff    <= 1'b0;
         quat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
         x_ff    <= x_in;
         y_ff    <= y_in;
         yaw_ff  <= yaw_in;
         iter_ff <= iter_in;
         neg_ff  <= neg_in;
         quat_ff <= quat_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
         op_ff   <= req_tuser;
      end
      prod_ff <= mul_p;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_tdata = {sin_ff, cos_ff, yaw_ff, y_ff, x_ff};

`ifndef SYNTH
   // The yaw accumulator never leaves [-pi, pi].
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      (yaw_ff <= PI_YAW) && (yaw_ff >= -PI_YAW))
      else $error("yaw accumulator out of range");

   // Input and result sides are never open in the same cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   // The rotation counter never passes the last iteration while rotating.
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT) |-> (iter_ff <= ITER_LAST))
      else $error("CORDIC iteration count overrun");

   // Taking a result returns the block to accepting items.
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("block not idle after result taken");
`endif

endmodule

[test/planar_dead_reckoning_tb.sv]
// ----------------------------------------------------------------------------
// Planar dead reckoning testbench
// Drives pose loads and motion updates into the block, predicts every
// returned pose with an independent fixed-point odometry model, and checks
// each result item field by field under several sender and receiver
// idling patterns and both settings of the enable bit.
// ----------------------------------------------------------------------------
module planar_dead_reckoning_tb;
   import pdr_pkg::*;

   localparam int     ROTATIONS     = CORDIC_ITERATIONS_DEF;
   localparam int     SETTLE_CYCLES = 2 * ROTATIONS + 16;
   localparam int     QUIET_LIMIT   = 4000;
   localparam longint PI_VAL        = longint'(PI_Q29);
   localparam longint HALF_PI_VAL   = longint'(HALF_PI_Q29);
   localparam longint TWO_PI_VAL    = longint'(TWO_PI_Q29);
   localparam longint GAIN_VAL      = longint'(GAIN_Q30);
   localparam longint ONE_VAL       = longint'(ONE_Q30);

   // Input item fields, laid out exactly as req_tdata.
   typedef struct packed {
      logic [31:0] load_yaw;
      logic [47:0] load_y;
      logic [47:0] load_x;
      logic [15:0] time_step;
      logic [31:0] ang_vel;
      logic [31:0] lin_vel;
   } odo_item_type;

   // Result item fields, laid out exactly as rsp_tdata.
   typedef struct packed {
      logic [31:0] quat_z;
      logic [31:0] quat_w;
      logic [31:0] heading;
      logic [47:0] pos_y;
      logic [47:0] pos_x;
   } pose_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // speed, yaw rate, time step, load x, load y, load yaw
   logic [207:0] req_tdata  = '0;
   // opcode
   logic         req_tuser  = OP_UPDATE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // pos_x, pos_y, heading, quat_w, quat_z
   logic [191:0] rsp_tdata;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic         csr_data   = 1'b0;

   // Predicted pose state and enable bit.
   longint track_x      = 0;
   longint track_y      = 0;
   longint track_yaw    = 0;
   logic   track_enable = 1'b0;

   pose_type expected_poses[$];
   int       fail_count    = 0;
   int       quiet_cycles  = 0;
   int       send_idle_pct = 0;
   int       stall_pct     = 0;

   planar_dead_reckoning #(
      .CORDIC_ITERATIONS(ROTATIONS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Clock with a 12 unit period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Odometry predictor
   // ------------------------------------------------------------------------

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Sign-extend the low 48 bits, which gives the position wrap.
   function automatic longint wrap48(input longint v);
      logic [47:0] t;
      t = v[47:0];
      return longint'({{16{t[47]}}, t});
   endfunction

   // Arctangent of 2^-i in units of 2^-30 rad; exact powers of two from i = 10.
   function automatic longint arctan_step(input int i);
      case (i)
         0: return 843314857;
         1: return 497837829;
         2: return 263043837;
         3: return 133525159;
         4: return 67021687;
         5: return 33543516;
         6: return 16775851;
         7: return 8388437;
         8: return 4194283;
         9: return 2097149;
         default: return (i <= 30) ? (longint'(1) << (30 - i)) : 0;
      endcase
   endfunction

   // Rotation-mode CORDIC; the angle is in units of 2^-30 rad.
   function automatic void rotate_vector(input longint angle, output longint c,
                                         output longint s);
      longint xv, yv, zv, xs, ys;
      int     i;
      xv = GAIN_VAL;
      yv = 0;
      zv = angle;
      for (i = 0; i < ROTATIONS; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (zv >= 0) begin
            xv = xv - ys;
            yv = yv + xs;
            zv = zv - arctan_step(i);
         end else begin
            xv = xv + ys;
            yv = yv - xs;
            zv = zv + arctan_step(i);
         end
      end
      c = clip(xv, -ONE_VAL, ONE_VAL);
      s = clip(yv, -ONE_VAL, ONE_VAL);
   endfunction

   // Apply one accepted item to the predicted pose and return the result.
   function automatic pose_type advance_pose(input logic op, input odo_item_type f);
      longint   v, w, dt, inc, yaw, ang, c, s, dx, dy, qw, qz;
      logic     flip;
      pose_type p;
      v  = longint'($signed(f.lin_vel));
      w  = longint'($signed(f.ang_vel));
      dt = longint'(f.time_step);
      if (op == OP_LOAD) begin
         track_x   = wrap48(longint'(f.load_x));
         track_y   = wrap48(longint'(f.load_y));
         track_yaw = clip(longint'($signed(f.load_yaw)), -PI_VAL, PI_VAL);
      end else if (track_enable && dt != 0) begin
         // Saturated increment, then a single wrap back into range.
         inc = clip((w * dt) >>> 3, -PI_VAL, PI_VAL);
         yaw = track_yaw + inc;
         if (yaw > PI_VAL) yaw = yaw - TWO_PI_VAL;
         if (yaw < -PI_VAL) yaw = yaw + TWO_PI_VAL;
         track_yaw = yaw;
         // Fold the heading into the CORDIC range and undo it by negation.
         flip = 1'b0;
         ang  = yaw;
         if (ang > HALF_PI_VAL) begin
            ang  = ang - PI_VAL;
            flip = 1'b1;
         end else if (ang < -HALF_PI_VAL) begin
            ang  = ang + PI_VAL;
            flip = 1'b1;
         end
         rotate_vector(ang * 2, c, s);
         if (flip) begin
            c = -c;
            s = -s;
         end
         dx = (((v * c) >>> 30) * dt) >>> 16;
         dy = (((v * s) >>> 30) * dt) >>> 16;
         track_x = wrap48(track_x + dx);
         track_y = wrap48(track_y + dy);
      end
      // Q3.29 yaw read as 2^-30 units is half the yaw.
      rotate_vector(track_yaw, qw, qz);
      p.pos_x   = track_x[47:0];
      p.pos_y   = track_y[47:0];
      p.heading = track_yaw[31:0];
      p.quat_w  = qw[31:0];
      p.quat_z  = qz[31:0];
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking and watchdog
   // ------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Each accepted result item is compared with the oldest prediction.
   always @(posedge clock) begin : check_results
      pose_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_poses.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result item, expected none actual %h",
                     $time, rsp_tdata);
         end else begin
            want = expected_poses.pop_front();
            compare_field("pos_x", 64'(want.pos_x), 64'(got.pos_x));
            compare_field("pos_y", 64'(want.pos_y), 64'(got.pos_y));
            compare_field("heading", 64'(want.heading), 64'(got.heading));
            compare_field("quat_w", 64'(want.quat_w), 64'(got.quat_w));
            compare_field("quat_z", 64'(want.quat_z), 64'(got.quat_z));
         end
      end
   end

   // Receiver stalls at the rate of the current phase.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // End the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic wait_drained();
      while (expected_poses.size() != 0) @(posedge clock);
   endtask

   // Send one item, predicting its result at the accepting edge.
   task automatic send_item(input logic op, input odo_item_type f);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_poses.push_back(advance_pose(op, f));
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // The enable bit is only written once the block has gone idle.
   task automatic write_enable(input logic value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      track_enable = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly plausible odometry values, with full-range values mixed in.
   function automatic odo_item_type random_item();
      odo_item_type f;
      logic [63:0]  wide;
      f.lin_vel = ($urandom_range(3) == 0) ? $urandom
                                           : 32'($urandom_range(262144)) - 32'd131072;
      f.ang_vel = ($urandom_range(3) == 0) ? $urandom
                                           : 32'($urandom_range(524288)) - 32'd262144;
      case ($urandom_range(7))
         0: f.time_step = '0;
         1: f.time_step = 16'($urandom);
         default: f.time_step = 16'($urandom_range(6554, 1));
      endcase
      wide = {$urandom, $urandom};
      f.load_x = ($urandom_range(1) == 0) ? wide[47:0]
                 : 48'(64'($urandom_range(131072000)) - 64'd65536000);
      wide = {$urandom, $urandom};
      f.load_y = ($urandom_range(1) == 0) ? wide[47:0]
                 : 48'(64'($urandom_range(131072000)) - 64'd65536000);
      f.load_yaw = ($urandom_range(3) == 0) ? $urandom
                   : 32'($urandom_range(32'd3373259426)) - 32'd1686629713;
      return f;
   endfunction

   task automatic send_update(input logic [31:0] v, input logic [31:0] w,
                              input logic [15:0] dt);
      odo_item_type f;
      f = random_item();
      f.lin_vel   = v;
      f.ang_vel   = w;
      f.time_step = dt;
      send_item(OP_UPDATE, f);
   endtask

   task automatic send_load(input logic [47:0] x, input logic [47:0] y,
                            input logic [31:0] yaw);
      odo_item_type f;
      f = random_item();
      f.load_x   = x;
      f.load_y   = y;
      f.load_yaw = yaw;
      send_item(OP_LOAD, f);
   endtask

   // Out of reset the block is disabled: updates hold, loads still apply
   // and saturate an out-of-range yaw.
   task automatic test_disabled_hold();
      send_update(32'h7fffffff, 32'h7fffffff, 16'hffff);
      send_load(48'h7fff_ffff_ffff, 48'h8000_0000_0000, 32'h7fffffff);
      send_update(32'h80000000, 32'h80000000, 16'hffff);
      send_load(48'h0, 48'h0, 32'h80000000);
   endtask

   // Yaw increment saturation and the wrap at both ends.
   task automatic test_yaw_wrap();
      write_enable(1'b1);
      send_update(32'h00010000, 32'h00010000, 16'h0000);
      send_load(48'h0, 48'h0, 32'h0);
      send_update(32'h00010000, 32'h7fffffff, 16'hffff);
      send_update(32'h00010000, 32'h7fffffff, 16'hffff);
      send_update(32'h00010000, 32'h80000000, 16'hffff);
      send_update(32'h00010000, 32'h80000000, 16'hffff);
      send_load(48'h0, 48'h0, 32'(PI_VAL));
      send_update(32'h00010000, 32'h00010000, 16'd655);
      // Exactly minus pi is kept as it is.
      send_load(48'h0, 48'h0, 32'(-PI_VAL));
      send_update(32'h00010000, 32'h00000000, 16'd1);
      send_update(32'h00010000, 32'hffff0000, 16'd655);
   endtask

   // Largest speeds and time steps, with the position wrapping at 48 bits.
   task automatic test_position_wrap();
      send_load(48'h7fff_ffff_0000, 48'h8000_0000_ffff, 32'h0);
      send_update(32'h7fffffff, 32'h00000000, 16'hffff);
      send_load(48'h7fff_ffff_0000, 48'h8000_0000_ffff, 32'(-HALF_PI_VAL));
      send_update(32'h7fffffff, 32'h00000000, 16'hffff);
      send_update(32'h80000000, 32'h00000000, 16'hffff);
   endtask

   // Headings on and just past the quarter turns exercise the fold.
   task automatic test_quadrants();
      send_load(48'h0, 48'h0, 32'(HALF_PI_VAL));
      send_update(32'h00010000, 32'h00000000, 16'd1000);
      send_load(48'h0, 48'h0, 32'(HALF_PI_VAL + 1));
      send_update(32'h00010000, 32'h00000000, 16'd1000);
      send_load(48'h0, 48'h0, 32'(-HALF_PI_VAL - 1));
      send_update(32'h00010000, 32'h00000000, 16'd1000);
   endtask

   // One random phase; the first held_items run with the block disabled.
   task automatic run_traffic_phase(input int idle_pct, input int stall,
                                    input int count, input int held_items);
      odo_item_type f;
      logic         op;
      int           n;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      if (held_items > 0) write_enable(1'b0);
      for (n = 0; n < count; n++) begin
         if (n == held_items) write_enable(1'b1);
         // Let everything in flight come back now and then.
         if (n % 50 == 49) wait_drained();
         f  = random_item();
         op = ($urandom_range(99) < 15) ? OP_LOAD : OP_UPDATE;
         send_item(op, f);
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(0, 0, 160, 0);
      run_traffic_phase(48, 0, 160, 0);
      run_traffic_phase(0, 48, 160, 20);
      run_traffic_phase(15, 15, 160, 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_disabled_hold();
      test_yaw_wrap();
      test_position_wrap();
      test_quadrants();
      test_random_traffic();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_poses.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/pdr_pkg.sv
rtl/planar_dead_reckoning.sv
test/planar_dead_reckoning_tb.sv
